### hdl/ist_pkg.sv
package ist_pkg;

  // Table size and derived widths
  localparam int CAPACITY = 16;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int DATA_W   = 32;

  // Request codes
  localparam logic [1:0] OP_LOOKUP = 2'd0;
  localparam logic [1:0] OP_ADD    = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_t;

  // Table memory read request
  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
  } rd_req_t;

  // Table memory write request
  typedef struct packed {
    logic              en;
    logic [IDX_W-1:0]  addr;
    logic [DATA_W-1:0] data;
  } wr_req_t;

endpackage

### hdl/ist_ram.sv
module ist_ram (
  input  logic                      clk,
  input  ist_pkg::rd_req_t          rd,
  input  ist_pkg::wr_req_t          wr,
  output logic [ist_pkg::DATA_W-1:0] rd_data
);
  import ist_pkg::*;

  logic [DATA_W-1:0] mem [CAPACITY];

  // Write one entry
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // Read one entry, data registered
  always_ff @(posedge clk) begin
    if (rd.en) begin
      rd_data <= mem[rd.addr];
    end
  end

endmodule

### hdl/integer_set_table.sv
// Channel | Handshake          | Payload
// --------+--------------------+-----------------------------------------------
// in      | in_valid/in_ready  | op, value
// out     | out_valid/out_ready| found, removed_count, entry_count, overflow
//
// Every item makes one pass over the held entries through the table memory,
// one read a cycle; a remove writes survivors back in place during that pass.
// An item is taken only in the idle state; the scan state then reads the entries,
// and the finish state loads the result, appends an absent value on an add, and
// returns to idle, so a new item is taken only after the last one is through.
// Reset clears the fill count and empties the table at once. A result waits
// in the output register; the next item is taken while it waits, and the
// sequencer stalls only when it must load a new result.
module integer_set_table (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  op,
  input  logic signed [31:0] value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        found,
  output logic [4:0]  removed_count,
  output logic [4:0]  entry_count,
  output logic        overflow
);
  import ist_pkg::*;

  state_t            state, state_next;
  logic [1:0]        op_q;
  logic [DATA_W-1:0] value_q;
  logic [CNT_W-1:0]  fill_count;
  logic [CNT_W-1:0]  rd_idx;
  logic [CNT_W-1:0]  wr_idx;
  logic [CNT_W-1:0]  match_count;
  logic              hit;
  logic              rd_pend;

  rd_req_t           rd;
  wr_req_t           wr;
  logic [DATA_W-1:0] rd_data;

  logic              scan_more;
  logic              is_match;
  logic              slot_free;
  logic              add_ok;
  logic              full;

  ist_ram u_ram (
    .clk     (clk),
    .rd      (rd),
    .wr      (wr),
    .rd_data (rd_data)
  );

  assign scan_more = (rd_idx < fill_count);
  assign is_match  = (rd_data == value_q);
  assign slot_free = !out_valid || out_ready;
  assign full      = (fill_count >= CNT_W'(CAPACITY));
  assign add_ok    = (op_q == OP_ADD) && !hit && !full;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (in_valid) state_next = ST_SCAN;
      ST_SCAN:   if (!rd_pend && !scan_more) state_next = ST_FINISH;
      ST_FINISH: if (slot_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // Memory requests and handshake
  always_comb begin
    in_ready = 1'b0;
    rd       = '0;
    wr       = '0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
      end
      ST_SCAN: begin
        rd.en   = scan_more;
        rd.addr = rd_idx[IDX_W-1:0];
        // compact survivors of a remove toward the front
        if (rd_pend && (op_q == OP_REMOVE) && !is_match) begin
          wr.en   = 1'b1;
          wr.addr = wr_idx[IDX_W-1:0];
          wr.data = rd_data;
        end
      end
      ST_FINISH: begin
        // append an absent value
        if (slot_free && add_ok) begin
          wr.en   = 1'b1;
          wr.addr = fill_count[IDX_W-1:0];
          wr.data = value_q;
        end
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      fill_count <= '0;
      rd_pend    <= 1'b0;
      out_valid  <= 1'b0;
      rd_idx     <= '0;
      wr_idx     <= '0;
    end else begin
      state   <= state_next;
      rd_pend <= rd.en;
      // load a new result, else drop the one taken
      if (state == ST_FINISH && slot_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          rd_idx <= '0;
          wr_idx <= '0;
        end
        ST_SCAN: begin
          if (scan_more) rd_idx <= rd_idx + 1'b1;
          if (wr.en) wr_idx <= wr_idx + 1'b1;
        end
        ST_FINISH: begin
          if (slot_free) begin
            if (op_q == OP_REMOVE) begin
              fill_count <= wr_idx;
            end else if (add_ok) begin
              fill_count <= fill_count + 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Request and scan payload
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_valid) begin
      op_q        <= op;
      value_q     <= $unsigned(value);
      hit         <= 1'b0;
      match_count <= '0;
    end else if (state == ST_SCAN && rd_pend && is_match) begin
      hit         <= 1'b1;
      match_count <= match_count + 1'b1;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (state == ST_FINISH && slot_free) begin
      found         <= hit;
      removed_count <= (op_q == OP_REMOVE) ? 5'(match_count) : 5'd0;
      overflow      <= (op_q == OP_ADD) && !hit && full;
      if (op_q == OP_REMOVE) begin
        entry_count <= 5'(wr_idx);
      end else if (add_ok) begin
        entry_count <= 5'(fill_count + 1'b1);
      end else begin
        entry_count <= 5'(fill_count);
      end
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= CNT_W'(CAPACITY))
    else $error("fill count above capacity");

  a_wr_behind_rd: assert property (@(posedge clk) disable iff (rst)
    wr_idx <= rd_idx)
    else $error("compaction write passed the read pointer");

  a_accept_scan: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> state == ST_SCAN)
    else $error("accepted item did not start a scan");

  a_scan_write: assert property (@(posedge clk) disable iff (rst)
    state == ST_SCAN && wr.en |-> rd_pend && op_q == OP_REMOVE)
    else $error("scan write without read data of a remove");

  a_rm_fill: assert property (@(posedge clk) disable iff (rst)
    state == ST_FINISH && op_q == OP_REMOVE |-> wr_idx + match_count == fill_count)
    else $error("remove count does not add up");

endmodule
